### hw/rtl/asdec_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the alternating shift text decoder.
// No dependencies; every other file in hw/rtl imports this package.

package asdec_pkg;

    localparam logic [7:0] CH_LT = 8'h3C;
    localparam logic [7:0] CH_E  = 8'h45;
    localparam logic [7:0] CH_GT = 8'h3E;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    localparam logic [7:0] PERIOD_RESET = 8'd6;
    localparam int         GRP_DEPTH    = 4;
    localparam int         GRP_SLOTS    = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_stream;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
    } out_item_t;

    // One character of a group: shifted, or passed through as is.
    typedef struct packed {
        logic       lit;
        logic [7:0] ch;
    } op_t;

    // All characters produced by one input word.
    typedef struct packed {
        logic [1:0]                cnt;
        op_t [GRP_SLOTS-1:0]       op;
    } grp_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LT   = 2'd1,
        PH_LT_E = 2'd2
    } phase_t;

    typedef struct packed {
        logic   push;
        phase_t phase;
    } front_stat_t;

endpackage

### hw/rtl/asdec_front.sv
`timescale 1ns / 1ps
// Front end: takes input words, tracks the escape prefix and builds the
// group of characters each word yields. Depends on asdec_pkg.

module asdec_front
    import asdec_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  in_item_t    item,
    output grp_t        grp,
    output front_stat_t stat
);

    phase_t phase_reg;
    phase_t phase_next;
    logic [7:0] b;
    logic       eos;

    assign b   = item.in_byte;
    assign eos = item.end_of_stream;

    always_comb
    begin
        phase_next = PH_IDLE;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (b == CH_LT)
                    phase_next = PH_LT;
            end
            PH_LT:
            begin
                if (b == CH_E)
                    phase_next = PH_LT_E;
            end
            PH_LT_E:
            begin
                phase_next = PH_IDLE;
            end
            default:
            begin
                if (b == CH_LT)
                    phase_next = PH_LT;
            end
        endcase
        if (eos)
            phase_next = PH_IDLE;
    end

    always_comb
    begin
        grp = '0;
        unique case (phase_reg)
            PH_LT:
            begin
                if (b == CH_E)
                begin
                    if (eos)
                    begin
                        grp.op[0] = '{lit: 1'b0, ch: CH_LT};
                        grp.op[1] = '{lit: 1'b0, ch: CH_E};
                        grp.cnt   = 2'd2;
                    end
                end
                else
                begin
                    grp.op[0] = '{lit: 1'b0, ch: CH_LT};
                    grp.op[1] = '{lit: 1'b0, ch: b};
                    grp.cnt   = 2'd2;
                end
            end
            PH_LT_E:
            begin
                if (b == CH_GT)
                begin
                    grp.op[0] = '{lit: 1'b1, ch: CH_LF};
                    grp.cnt   = 2'd1;
                end
                else
                begin
                    grp.op[0] = '{lit: 1'b0, ch: CH_LT};
                    grp.op[1] = '{lit: 1'b0, ch: CH_E};
                    grp.op[2] = '{lit: 1'b0, ch: b};
                    grp.cnt   = 2'd3;
                end
            end
            default:
            begin
                if (b == CH_LT)
                begin
                    if (eos)
                    begin
                        grp.op[0] = '{lit: 1'b0, ch: CH_LT};
                        grp.cnt   = 2'd1;
                    end
                end
                else if (b != CH_CR && b != CH_LF)
                begin
                    grp.op[0] = '{lit: 1'b0, ch: b};
                    grp.cnt   = 2'd1;
                end
            end
        endcase
        stat.push  = accept && (grp.cnt != 2'd0);
        stat.phase = phase_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= PH_IDLE;
        else if (accept)
            phase_reg <= phase_next;
    end

endmodule

### hw/rtl/asdec_fifo.sv
`timescale 1ns / 1ps
// Short queue of character groups between front and back end.
// Depends on asdec_pkg.

module asdec_fifo
    import asdec_pkg::*;
#(
    parameter int DEPTH = GRP_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  grp_t wr_grp,
    input  logic rd_en,
    output grp_t rd_grp,
    output logic full,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    grp_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_wr;
    logic          do_rd;

    assign full   = (cnt_reg == DEPTH_CNT);
    assign empty  = (cnt_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_grp = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_grp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

### hw/rtl/asdec_back.sv
`timescale 1ns / 1ps
// Back end: holds the period, step counter and result register; shifts one
// character per cycle from the head group unless the result waits unpopped. Depends on asdec_pkg.

module asdec_back
    import asdec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       period_we,
    input  logic [7:0] period_wdata,
    input  grp_t       head,
    input  logic       grp_empty,
    output logic       grp_pop,
    output out_item_t  result,
    output logic       empty,
    input  logic       pop
);

    logic [7:0] period_reg;
    logic [7:0] step_reg;
    logic [7:0] step_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       last_reg;
    logic       last_next;

    logic       load;
    logic       taken;
    op_t        op;
    logic [7:0] eff_period;
    logic [8:0] inc;
    logic [7:0] s;
    logic [8:0] amt_sum;
    logic [7:0] amt;

    assign taken = pop && valid_reg;
    assign load  = !grp_empty && (!valid_reg || taken);
    assign op    = head.op[idx_reg];

    always_comb
    begin
        eff_period = (period_reg == 8'd0) ? 8'd1 : period_reg;
        inc        = {1'b0, step_reg} + 9'd1;
        s          = (inc > {1'b0, eff_period}) ? 8'd1 : inc[7:0];
        amt_sum    = {1'b0, s} + 9'd1;
        amt        = amt_sum[8:1];

        last_next  = (idx_reg == head.cnt - 2'd1);
        grp_pop    = load && last_next;
        idx_next   = idx_reg;
        step_next  = step_reg;
        byte_next  = byte_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = last_next ? 2'd0 : idx_reg + 2'd1;
            if (op.lit)
                byte_next = op.ch;
            else
            begin
                step_next = s;
                byte_next = s[0] ? op.ch - amt : op.ch + amt;
            end
        end
        else if (taken)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            step_reg   <= 8'd0;
            idx_reg    <= 2'd0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (period_we)
                period_reg <= period_wdata;
            step_reg  <= step_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // hold the payload while the result waits
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        if (load)
            last_reg <= last_next;
    end

    assign result.out_byte = byte_reg;
    assign result.run_last = last_reg;
    assign empty           = !valid_reg;

endmodule

### hw/rtl/alternating_shift_text_decoder.sv
`timescale 1ns / 1ps
// Alternating shift text decoder, top level. Depends on asdec_pkg,
// asdec_front, asdec_fifo and asdec_back.

// A word is taken whenever push is high and full is low, one per cycle. Each
// word yields zero to three decoded characters: one for most text, none for
// CR, LF or a held escape prefix, and up to three for a broken escape. Results
// leave one per cycle while pop is high, through a single output register,
// so sustained throughput is one result per cycle while groups wait. With an
// empty queue, a word's group goes into the queue, then its first result into
// the output register. The front end turns each word into a character group,
// queued if non-empty (GRP_DEPTH_P groups); full rises once it is full. The
// period register may be written only while no decoded character is pending.

module alternating_shift_text_decoder
    import asdec_pkg::*;
#(
    parameter int GRP_DEPTH_P = GRP_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  in_item_t   item,
    output logic       empty,
    input  logic       pop,
    output out_item_t  result,
    input  logic       period_we,
    input  logic [7:0] period_wdata
);

    logic        accept;
    grp_t        fr_grp;
    front_stat_t fr_stat;
    grp_t        head;
    logic        grp_full;
    logic        grp_empty;
    logic        grp_pop;

    assign full   = grp_full;
    assign accept = push && !grp_full;

    asdec_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .grp    (fr_grp),
        .stat   (fr_stat)
    );

    asdec_fifo #(
        .DEPTH (GRP_DEPTH_P)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (fr_stat.push),
        .wr_grp (fr_grp),
        .rd_en  (grp_pop),
        .rd_grp (head),
        .full   (grp_full),
        .empty  (grp_empty)
    );

    asdec_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .period_we    (period_we),
        .period_wdata (period_wdata),
        .head         (head),
        .grp_empty    (grp_empty),
        .grp_pop      (grp_pop),
        .result       (result),
        .empty        (empty),
        .pop          (pop)
    );

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        grp_pop |-> !grp_empty)
        else $error("group popped from empty queue");

    a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        !grp_empty |-> (head.cnt != 2'd0))
        else $error("queued group holds no characters");

    a_eos_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.end_of_stream) |=> (fr_stat.phase == PH_IDLE))
        else $error("escape prefix survived end of stream");

    a_pop_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (grp_pop && !empty && !pop) |-> 1'b0)
        else $error("result register overwritten while waiting");

endmodule
